// File: rtl/nll_pkg.sv
package nll_pkg;

  typedef enum logic [4:0] {
    PH_START,
    PH_SIGN,
    PH_ZERO,
    PH_DEC,
    PH_OCT,
    PH_FDIG,
    PH_DOT,
    PH_FRAC,
    PH_EXP,
    PH_EXPSGN,
    PH_EXPDIG,
    PH_HEX0,
    PH_HEX,
    PH_BIN0,
    PH_BIN,
    PH_F32,
    PH_F64,
    PH_USUF,
    PH_BAD
  } phase_e;

  typedef enum logic [3:0] {
    TK_OTHER,
    TK_WS,
    TK_U,
    TK_X,
    TK_B,
    TK_F,
    TK_D,
    TK_DOT,
    TK_E,
    TK_SIGN
  } tok_e;

  typedef enum logic [2:0] {
    KIND_INVALID,
    KIND_SINT,
    KIND_UINT,
    KIND_F32,
    KIND_F64,
    KIND_DFLOAT
  } kind_e;

  // one classified character as it travels from front to back
  typedef struct packed {
    tok_e       tok;
    logic       is_hex;
    logic       is_dig;
    logic [3:0] hval;
    logic       last;
  } cls_t;

  localparam logic [4:0] F32_DIGITS = 5'd8;
  localparam logic [4:0] F64_DIGITS = 5'd16;

endpackage

// File: rtl/nll_if.sv
interface nll_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface nll_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] value;
  logic        overflowed;
  logic        nonzero;

  modport source (output valid, output kind, output value, output overflowed,
                  output nonzero, input ready);
  modport sink   (input valid, input kind, input value, input overflowed,
                  input nonzero, output ready);
endinterface

// File: rtl/nll_front.sv
module nll_front (
  nll_in_if.sink        in_i,
  input  logic          full_i,
  output logic          push_o,
  output nll_pkg::cls_t cls_o
);

  logic [7:0] c;

  assign c         = in_i.char_code;
  assign in_i.ready = !full_i;
  assign push_o    = in_i.valid && !full_i;

  always_comb begin
    cls_o.is_hex = 1'b0;
    cls_o.is_dig = 1'b0;
    cls_o.hval   = 4'd0;
    cls_o.last   = in_i.last_char;
    if (c inside {["0":"9"]}) begin
      cls_o.is_hex = 1'b1;
      cls_o.is_dig = 1'b1;
      cls_o.hval   = 4'(c - 8'h30);
    end else if (c inside {["a":"f"]}) begin
      cls_o.is_hex = 1'b1;
      cls_o.hval   = 4'(c - 8'h57);
    end else if (c inside {["A":"F"]}) begin
      cls_o.is_hex = 1'b1;
      cls_o.hval   = 4'(c - 8'h37);
    end

    if (c inside {[8'd9:8'd13], 8'd32}) begin
      cls_o.tok = nll_pkg::TK_WS;
    end else begin
      case (c)
        "U":      cls_o.tok = nll_pkg::TK_U;
        "x", "X": cls_o.tok = nll_pkg::TK_X;
        "b", "B": cls_o.tok = nll_pkg::TK_B;
        "f", "F": cls_o.tok = nll_pkg::TK_F;
        "d", "D": cls_o.tok = nll_pkg::TK_D;
        ".":      cls_o.tok = nll_pkg::TK_DOT;
        "e", "E": cls_o.tok = nll_pkg::TK_E;
        "+", "-": cls_o.tok = nll_pkg::TK_SIGN;
        default:  cls_o.tok = nll_pkg::TK_OTHER;
      endcase
    end
  end

endmodule

// File: rtl/nll_fifo.sv
module nll_fifo #(
  parameter int DEPTH = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  nll_pkg::cls_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output nll_pkg::cls_t data_o,
  output logic          empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  nll_pkg::cls_t    mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/nll_back.sv
module nll_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  nll_pkg::cls_t cls_i,
  output logic          pop_o,
  nll_out_if.source     out_o
);

  nll_pkg::phase_e phase_q, phase_d;
  logic [63:0]     acc_q, acc_d;
  logic            ovf_q, ovf_d;
  logic [4:0]      cnt_q, cnt_d;
  logic            usuf_q, usuf_d;
  logic            trail_q, trail_d;

  logic            out_valid_q;
  nll_pkg::kind_e  kind_q, kind_d;
  logic [63:0]     value_q, value_d;
  logic            ovfo_q, ovfo_d;
  logic            nz_q, nz_d;

  logic            is_ws, is_feed, oct_dig, bin_dig, zero_dig;
  logic [67:0]     scaled, sum;

  assign is_ws    = (cls_i.tok == nll_pkg::TK_WS);
  assign is_feed  = !is_ws && !trail_q;
  assign oct_dig  = cls_i.is_dig && (cls_i.hval < 4'd8);
  assign bin_dig  = cls_i.is_dig && (cls_i.hval < 4'd2);
  assign zero_dig = cls_i.is_dig && (cls_i.hval == 4'd0);

  // a final character waits here until the previous result has left
  assign pop_o = !empty_i && (!cls_i.last || !out_valid_q || out_o.ready);

  // acc * base + digit, base picked by the phase
  always_comb begin
    case (phase_q)
      nll_pkg::PH_DEC: scaled = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0};
      nll_pkg::PH_OCT: scaled = {1'b0, acc_q, 3'b000};
      nll_pkg::PH_HEX: scaled = {acc_q, 4'b0000};
      default:         scaled = {3'b000, acc_q, 1'b0};
    endcase
    sum = scaled + {64'd0, cls_i.hval};
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (is_ws) begin
      phase_d = phase_q;
    end else if (trail_q) begin
      phase_d = nll_pkg::PH_BAD;
    end else begin
      case (phase_q)
        nll_pkg::PH_START: begin
          if (zero_dig)                        phase_d = nll_pkg::PH_ZERO;
          else if (cls_i.is_dig)               phase_d = nll_pkg::PH_DEC;
          else if (cls_i.tok == nll_pkg::TK_SIGN) phase_d = nll_pkg::PH_SIGN;
          else if (cls_i.tok == nll_pkg::TK_DOT)  phase_d = nll_pkg::PH_DOT;
          else                                 phase_d = nll_pkg::PH_BAD;
        end
        nll_pkg::PH_SIGN: begin
          if (cls_i.is_dig)                    phase_d = nll_pkg::PH_FDIG;
          else if (cls_i.tok == nll_pkg::TK_DOT) phase_d = nll_pkg::PH_DOT;
          else                                 phase_d = nll_pkg::PH_BAD;
        end
        nll_pkg::PH_ZERO: begin
          if (oct_dig)                         phase_d = nll_pkg::PH_OCT;
          else if (cls_i.is_dig)               phase_d = nll_pkg::PH_FDIG;
          else begin
            case (cls_i.tok)
              nll_pkg::TK_U:   phase_d = nll_pkg::PH_USUF;
              nll_pkg::TK_X:   phase_d = nll_pkg::PH_HEX0;
              nll_pkg::TK_B:   phase_d = nll_pkg::PH_BIN0;
              nll_pkg::TK_F:   phase_d = nll_pkg::PH_F32;
              nll_pkg::TK_D:   phase_d = nll_pkg::PH_F64;
              nll_pkg::TK_DOT: phase_d = nll_pkg::PH_DOT;
              nll_pkg::TK_E:   phase_d = nll_pkg::PH_EXP;
              default:         phase_d = nll_pkg::PH_BAD;
            endcase
          end
        end
        nll_pkg::PH_DEC, nll_pkg::PH_OCT, nll_pkg::PH_FDIG: begin
          if (cls_i.is_dig) begin
            if (phase_q == nll_pkg::PH_OCT && !oct_dig) phase_d = nll_pkg::PH_FDIG;
          end else if (cls_i.tok == nll_pkg::TK_U && phase_q != nll_pkg::PH_FDIG) begin
            phase_d = nll_pkg::PH_USUF;
          end else if (cls_i.tok == nll_pkg::TK_DOT) begin
            phase_d = nll_pkg::PH_DOT;
          end else if (cls_i.tok == nll_pkg::TK_E) begin
            phase_d = nll_pkg::PH_EXP;
          end else begin
            phase_d = nll_pkg::PH_BAD;
          end
        end
        nll_pkg::PH_DOT: begin
          phase_d = cls_i.is_dig ? nll_pkg::PH_FRAC : nll_pkg::PH_BAD;
        end
        nll_pkg::PH_FRAC: begin
          if (cls_i.is_dig)                    phase_d = nll_pkg::PH_FRAC;
          else if (cls_i.tok == nll_pkg::TK_E) phase_d = nll_pkg::PH_EXP;
          else                                 phase_d = nll_pkg::PH_BAD;
        end
        nll_pkg::PH_EXP: begin
          if (cls_i.is_dig)                       phase_d = nll_pkg::PH_EXPDIG;
          else if (cls_i.tok == nll_pkg::TK_SIGN) phase_d = nll_pkg::PH_EXPSGN;
          else                                    phase_d = nll_pkg::PH_BAD;
        end
        nll_pkg::PH_EXPSGN, nll_pkg::PH_EXPDIG: begin
          phase_d = cls_i.is_dig ? nll_pkg::PH_EXPDIG : nll_pkg::PH_BAD;
        end
        nll_pkg::PH_HEX0, nll_pkg::PH_HEX: begin
          if (cls_i.is_hex) phase_d = nll_pkg::PH_HEX;
          else if (phase_q == nll_pkg::PH_HEX && cls_i.tok == nll_pkg::TK_U)
            phase_d = nll_pkg::PH_USUF;
          else phase_d = nll_pkg::PH_BAD;
        end
        nll_pkg::PH_BIN0, nll_pkg::PH_BIN: begin
          if (bin_dig) phase_d = nll_pkg::PH_BIN;
          else if (phase_q == nll_pkg::PH_BIN && cls_i.tok == nll_pkg::TK_U)
            phase_d = nll_pkg::PH_USUF;
          else phase_d = nll_pkg::PH_BAD;
        end
        nll_pkg::PH_F32: begin
          phase_d = (cls_i.is_hex && cnt_q < nll_pkg::F32_DIGITS) ?
                    nll_pkg::PH_F32 : nll_pkg::PH_BAD;
        end
        nll_pkg::PH_F64: begin
          phase_d = (cls_i.is_hex && cnt_q < nll_pkg::F64_DIGITS) ?
                    nll_pkg::PH_F64 : nll_pkg::PH_BAD;
        end
        default: phase_d = nll_pkg::PH_BAD;
      endcase
    end
  end

  // datapath updates
  always_comb begin
    acc_d   = acc_q;
    ovf_d   = ovf_q;
    cnt_d   = cnt_q;
    usuf_d  = usuf_q;
    trail_d = trail_q || (is_ws && phase_q != nll_pkg::PH_START);
    if (is_feed) begin
      case (phase_q)
        nll_pkg::PH_START: begin
          if (cls_i.is_dig) acc_d = {60'd0, cls_i.hval};
        end
        nll_pkg::PH_ZERO: begin
          if (oct_dig) begin
            acc_d = {60'd0, cls_i.hval};
          end else if (!cls_i.is_dig) begin
            if (cls_i.tok == nll_pkg::TK_U) usuf_d = 1'b1;
            if (cls_i.tok == nll_pkg::TK_F || cls_i.tok == nll_pkg::TK_D) begin
              acc_d = '0;
              cnt_d = '0;
            end
          end
        end
        nll_pkg::PH_HEX0: begin
          if (cls_i.is_hex) acc_d = {60'd0, cls_i.hval};
        end
        nll_pkg::PH_BIN0: begin
          if (bin_dig) acc_d = {60'd0, cls_i.hval};
        end
        nll_pkg::PH_DEC, nll_pkg::PH_OCT, nll_pkg::PH_HEX, nll_pkg::PH_BIN: begin
          if ((phase_q == nll_pkg::PH_DEC && cls_i.is_dig) ||
              (phase_q == nll_pkg::PH_OCT && oct_dig) ||
              (phase_q == nll_pkg::PH_HEX && cls_i.is_hex) ||
              (phase_q == nll_pkg::PH_BIN && bin_dig)) begin
            // saturate once and hold
            if (!ovf_q) begin
              if (sum[67:64] != 4'd0) begin
                ovf_d = 1'b1;
                acc_d = '1;
              end else begin
                acc_d = sum[63:0];
              end
            end
          end else if (!cls_i.is_dig && cls_i.tok == nll_pkg::TK_U) begin
            usuf_d = 1'b1;
          end
        end
        nll_pkg::PH_F32, nll_pkg::PH_F64: begin
          if (phase_d == phase_q) begin
            acc_d = {acc_q[59:0], cls_i.hval};
            cnt_d = cnt_q + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // result from the updated state
  always_comb begin
    kind_d  = nll_pkg::KIND_INVALID;
    value_d = '0;
    ovfo_d  = 1'b0;
    nz_d    = 1'b0;
    case (phase_d)
      nll_pkg::PH_ZERO, nll_pkg::PH_DEC, nll_pkg::PH_OCT, nll_pkg::PH_HEX,
      nll_pkg::PH_BIN, nll_pkg::PH_USUF: begin
        kind_d  = usuf_d ? nll_pkg::KIND_UINT : nll_pkg::KIND_SINT;
        value_d = acc_d;
        ovfo_d  = ovf_d;
        nz_d    = (acc_d != '0);
      end
      nll_pkg::PH_F32: begin
        if (cnt_d == nll_pkg::F32_DIGITS) begin
          kind_d  = nll_pkg::KIND_F32;
          value_d = {32'd0, acc_d[31:0]};
        end
      end
      nll_pkg::PH_F64: begin
        if (cnt_d == nll_pkg::F64_DIGITS) begin
          kind_d  = nll_pkg::KIND_F64;
          value_d = acc_d;
        end
      end
      nll_pkg::PH_FDIG, nll_pkg::PH_FRAC, nll_pkg::PH_EXPDIG: begin
        kind_d = nll_pkg::KIND_DFLOAT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nll_pkg::PH_START;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      cnt_q   <= '0;
      usuf_q  <= 1'b0;
      trail_q <= 1'b0;
    end else if (pop_o) begin
      if (cls_i.last) begin
        phase_q <= nll_pkg::PH_START;
        acc_q   <= '0;
        ovf_q   <= 1'b0;
        cnt_q   <= '0;
        usuf_q  <= 1'b0;
        trail_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        ovf_q   <= ovf_d;
        cnt_q   <= cnt_d;
        usuf_q  <= usuf_d;
        trail_q <= trail_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && cls_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && cls_i.last) begin
      kind_q  <= kind_d;
      value_q <= value_d;
      ovfo_q  <= ovfo_d;
      nz_q    <= nz_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = kind_q;
  assign out_o.value      = value_q;
  assign out_o.overflowed = ovfo_q;
  assign out_o.nonzero    = nz_q;

endmodule

// File: rtl/numeric_literal_lexer.sv
// Numeric literal lexer: takes one character per transfer on in_i and, on the
// character marked last_char, delivers one result on out_o (kind, 64-bit value,
// overflow and nonzero flags). It sustains one character per cycle unless the
// back stalls: the front classifies each character and writes it into a
// QUEUE_DEPTH-entry queue, the back advances the lexer state and the shift-add
// accumulator for one queued character per cycle, and a single output register
// holds the result. Only a final character stalls the back, and only while the
// previous result is still waiting on out_o.ready. The result is registered:
// out_o.valid rises as the back pops its final character from the queue.
module numeric_literal_lexer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nll_in_if.sink     in_i,
  nll_out_if.source  out_o
);

  nll_pkg::cls_t push_cls, head_cls;
  logic          push, pop, q_full, q_empty;

  nll_front u_front (
    .in_i   (in_i),
    .full_i (q_full),
    .push_o (push),
    .cls_o  (push_cls)
  );

  nll_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cls),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (head_cls),
    .empty_o (q_empty)
  );

  nll_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (q_empty),
    .cls_i   (head_cls),
    .pop_o   (pop),
    .out_o   (out_o)
  );

  a_ovf_saturates : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overflowed |-> out_o.value == '1)
    else $error("overflow without saturated value");

  a_no_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == nll_pkg::KIND_INVALID ||
                    out_o.kind == nll_pkg::KIND_DFLOAT)
    |-> out_o.value == '0 && !out_o.overflowed && !out_o.nonzero)
    else $error("payload on invalid or unconverted result");

  a_int_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == nll_pkg::KIND_SINT ||
                    out_o.kind == nll_pkg::KIND_UINT)
    |-> out_o.nonzero == (out_o.value != '0))
    else $error("nonzero flag disagrees with value");

  a_float_flags : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == nll_pkg::KIND_F32 ||
                    out_o.kind == nll_pkg::KIND_F64)
    |-> !out_o.overflowed && !out_o.nonzero)
    else $error("integer flags on float bits result");

endmodule
